### rtl/keyed_slot_dedup_allocator_macros.svh
// Assertion macros shared by the keyed slot allocator RTL.
`ifndef KEYED_SLOT_DEDUP_ALLOCATOR_MACROS_SVH
`define KEYED_SLOT_DEDUP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define KSDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KSDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ksda_pkg.sv
// Package: sizes, payload types, codes and control structs of the keyed slot allocator.
`timescale 1ns / 1ps
package ksda_pkg;

  localparam int unsigned SLOTS    = 16;
  localparam int unsigned ID_BYTES = 64;
  localparam int unsigned WORDS    = (ID_BYTES + 7) / 8;
  localparam int unsigned KEY_W    = 64;

  localparam int unsigned SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WAW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CCW = $clog2(WORDS + 1);

  localparam logic OP_CHUNK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_ALLOCATED = 3'd1;
  localparam logic [2:0] ST_EMPTY_KEY = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key_chunk;
    logic             chunk_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] slot_number;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic decide;
    logic write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic beat_clear;
    logic beat_last;
    logic alloc;
    logic wr_done;
  } dp_stat_t;

endpackage

### rtl/ksda_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module ksda_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ksda_ctrl.sv
// Controller state machine: sequences chunk evaluation, decision and key write-back.
`timescale 1ns / 1ps
`include "keyed_slot_dedup_allocator_macros.svh"
module ksda_ctrl
  import ksda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_WRITE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.beat_clear || !stat.beat_last) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = stat.alloc ? S_WRITE : S_IDLE;
      end
      S_WRITE: begin
        if (stat.wr_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.capture = start && (state_r == S_IDLE);
  assign cmd.eval    = (state_r == S_EVAL);
  assign cmd.decide  = (state_r == S_DECIDE);
  assign cmd.write   = (state_r == S_WRITE);

  `KSDA_ASSERT_NEXT(a_accept_to_eval, clk, rst_n, start && !busy, state_r == S_EVAL, "accepted beat not evaluated")
  `KSDA_ASSERT_NEXT(a_write_holds, clk, rst_n, state_r == S_WRITE && !stat.wr_done, state_r == S_WRITE, "key write sweep cut short")
  `KSDA_ASSERT_NOW(a_decide_after_eval, clk, rst_n, state_r == S_DECIDE, $past(state_r == S_EVAL), "decision without last-chunk evaluation")

endmodule

### rtl/ksda_datapath.sv
// Datapath: key assembly, per-slot key RAM lanes, parallel compare, slot bookkeeping, result.
`timescale 1ns / 1ps
`include "keyed_slot_dedup_allocator_macros.svh"
module ksda_datapath
  import ksda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  in_item_t    in_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output out_item_t   out_item
);

  function automatic logic [SIW-1:0] lowest_set(input logic [SLOTS-1:0] vec);
    logic [SIW-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = SIW'(i);
      end
    end
    return idx;
  endfunction

  // Captured beat and configuration
  in_item_t    beat_r;
  logic [15:0] slot_base_r;

  // Key being received
  logic [CCW-1:0]   chunk_cnt_r;
  logic [CCW-1:0]   nz_cnt_r;
  logic             term_r;
  logic             too_long_r;
  logic [KEY_W-1:0] inkey_r [WORDS];
  logic [SLOTS-1:0] match_r;

  // Slot bookkeeping
  logic [SLOTS-1:0] slot_used_r;
  logic [CCW-1:0]   slot_nz_r [SLOTS];
  logic [SLOTS-1:0] hit_r;
  logic             empty_r;
  logic [SIW-1:0]   alloc_slot_r;
  logic [WAW-1:0]   wr_cnt_r;

  // Result
  logic      out_valid_r;
  out_item_t out_item_r;

  // Absorb and compare
  logic             active;
  logic [KEY_W-1:0] kept;
  logic             term_nxt;
  logic             too_long_nxt;
  logic [CCW-1:0]   nz_nxt;
  logic [SLOTS-1:0] match_nxt;
  logic [SLOTS-1:0] hit_nxt;
  logic [SLOTS-1:0] free_vec;
  logic             any_free;
  logic [SIW-1:0]   free_idx;
  logic [SIW-1:0]   hit_idx;

  // RAM lanes, one per slot
  logic [WAW-1:0]   ram_addr;
  logic [KEY_W-1:0] ram_wdata;
  logic [SLOTS-1:0] ram_we;
  logic [KEY_W-1:0] lane_rdata [SLOTS];

  assign active = (chunk_cnt_r < CCW'(WORDS));

  always_comb begin
    int pos;
    logic [7:0] byte_v;
    kept         = '0;
    term_nxt     = term_r;
    too_long_nxt = too_long_r;
    for (int b = 0; b < 8; b++) begin
      pos    = int'(chunk_cnt_r) * 8 + b;
      byte_v = beat_r.key_chunk[8*b +: 8];
      if (!term_nxt) begin
        if (byte_v == 8'd0) begin
          term_nxt = 1'b1;
        end else if (pos >= int'(ID_BYTES) - 1) begin
          too_long_nxt = 1'b1;
          term_nxt     = 1'b1;
        end else begin
          kept[8*b +: 8] = byte_v;
        end
      end
    end
  end

  assign nz_nxt = nz_cnt_r + CCW'(active && (kept != '0));

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match_nxt[s] = match_r[s] && (!active || (lane_rdata[s] == kept));
      // stored words past slot_nz are zero, as are unreceived incoming words
      hit_nxt[s]   = match_nxt[s] && slot_used_r[s] && (slot_nz_r[s] <= nz_nxt) &&
                     !too_long_nxt;
    end
  end

  assign free_vec = ~slot_used_r;
  assign any_free = |free_vec;
  assign free_idx = lowest_set(free_vec);
  assign hit_idx  = lowest_set(hit_r);

  assign ram_addr  = cmd.write ? wr_cnt_r : chunk_cnt_r[WAW-1:0];
  assign ram_wdata = (CCW'(wr_cnt_r) < nz_cnt_r) ? inkey_r[wr_cnt_r] : '0;

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      ram_we[s] = cmd.write && (alloc_slot_r == SIW'(s));
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_lane
    ksda_ram #(
      .WIDTH (KEY_W),
      .DEPTH (WORDS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[g]),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (lane_rdata[g])
    );
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      beat_r <= in_item;
    end
    if (cmd.eval && beat_r.opcode == OP_CHUNK && active) begin
      inkey_r[chunk_cnt_r[WAW-1:0]] <= kept;
    end
    if (cmd.eval) begin
      hit_r   <= hit_nxt;
      empty_r <= (nz_nxt == '0);
    end
    // record the word count only for the slot actually claimed
    if (cmd.decide && stat.alloc) begin
      alloc_slot_r        <= free_idx;
      slot_nz_r[free_idx] <= nz_cnt_r;
    end
    if (cmd.decide) begin
      wr_cnt_r <= '0;
    end else if (cmd.write) begin
      wr_cnt_r <= wr_cnt_r + WAW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_base_r <= '0;
      chunk_cnt_r <= '0;
      nz_cnt_r    <= '0;
      term_r      <= 1'b0;
      too_long_r  <= 1'b0;
      match_r     <= '1;
      slot_used_r <= '0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        slot_base_r <= cfg_data;
      end
      if (cmd.eval) begin
        if (beat_r.opcode == OP_CLEAR) begin
          chunk_cnt_r            <= '0;
          nz_cnt_r               <= '0;
          term_r                 <= 1'b0;
          too_long_r             <= 1'b0;
          match_r                <= '1;
          slot_used_r            <= '0;
          out_valid_r            <= 1'b1;
          out_item_r.slot_number <= '0;
          out_item_r.status      <= ST_CLEARED;
        end else if (active) begin
          chunk_cnt_r <= chunk_cnt_r + CCW'(1);
          nz_cnt_r    <= nz_nxt;
          term_r      <= term_nxt;
          too_long_r  <= too_long_nxt;
          match_r     <= match_nxt;
        end
      end
      if (cmd.decide) begin
        out_valid_r <= 1'b1;
        if (empty_r) begin
          out_item_r.slot_number <= '0;
          out_item_r.status      <= ST_EMPTY_KEY;
        end else if (|hit_r) begin
          out_item_r.slot_number <= 16'(slot_base_r + 16'(hit_idx));
          out_item_r.status      <= ST_FOUND;
        end else if (any_free) begin
          slot_used_r[free_idx]  <= 1'b1;
          out_item_r.slot_number <= 16'(slot_base_r + 16'(free_idx));
          out_item_r.status      <= ST_ALLOCATED;
        end else begin
          out_item_r.slot_number <= '0;
          out_item_r.status      <= ST_FULL;
        end
      end
      // drop the received key once the decision or the write-back is done
      if ((cmd.decide && !stat.alloc) || (cmd.write && stat.wr_done)) begin
        chunk_cnt_r <= '0;
        nz_cnt_r    <= '0;
        term_r      <= 1'b0;
        too_long_r  <= 1'b0;
        match_r     <= '1;
      end
    end
  end

  assign stat.beat_clear = (beat_r.opcode == OP_CLEAR);
  assign stat.beat_last  = beat_r.chunk_last;
  assign stat.alloc      = !empty_r && !(|hit_r) && any_free;
  assign stat.wr_done    = (wr_cnt_r == WAW'(WORDS - 1));

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `KSDA_ASSERT_NOW(a_one_lane_written, clk, rst_n, |ram_we, $onehot(ram_we), "key written to more than one slot")
  `KSDA_ASSERT_NEXT(a_alloc_claims_one, clk, rst_n, cmd.decide && stat.alloc, $countones(slot_used_r) == $countones($past(slot_used_r)) + 1, "allocation did not claim exactly one slot")
  `KSDA_ASSERT_NOW(a_clear_empties, clk, rst_n, out_valid_r && out_item_r.status == ST_CLEARED, slot_used_r == '0, "slots still used after clear")

endmodule

### rtl/keyed_slot_dedup_allocator.sv
// Top level of the keyed slot allocator: controller plus datapath.
`timescale 1ns / 1ps
// A key is fed as 64-bit chunk beats on start/in_item, accepted when start is
// high and busy is low. A chunk that is not last is evaluated only; the last
// chunk is evaluated, then decided, and when a new slot is claimed the key is
// written word by word (WORDS words, 8 by default) into that slot's RAM lane
// through its one write port. A clear beat is evaluated only. Each result is
// shown on out_item for exactly one cycle with out_valid high; the receiver
// cannot stall it, and the next beat may be accepted in that same cycle
// unless a slot is being written. cfg_ready is always high; write slot_base
// only while the block is idle. No clearing pass is needed after reset.
module keyed_slot_dedup_allocator
  import ksda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ksda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ksda_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### tb/keyed_slot_dedup_allocator_checker.sv
// Checker for the keyed slot allocator: predicts slot answers from accepted beats and compares.
`timescale 1ns / 1ps
module keyed_slot_dedup_allocator_checker
  import ksda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef logic [WORDS-1:0][KEY_W-1:0] key_words_t;

  key_words_t       stored_keys [SLOTS];
  logic [SLOTS-1:0] slot_taken;
  key_words_t       partial_key;
  int unsigned      words_taken;
  logic             key_ended;
  logic             key_overlong;
  logic [15:0]      base_reg;
  out_item_t        answers_q [$];
  int               errors = 0;

  function automatic void drop_partial_key();
    partial_key  = '0;
    words_taken  = 0;
    key_ended    = 1'b0;
    key_overlong = 1'b0;
  endfunction

  function automatic void wipe_slots();
    slot_taken = '0;
    foreach (stored_keys[i]) stored_keys[i] = '0;
    drop_partial_key();
  endfunction

  // Keep bytes up to the first zero; a character at the last byte position flags overlong.
  function automatic void absorb_chunk(logic [KEY_W-1:0] chunk);
    logic [KEY_W-1:0] kept;
    logic [7:0]       ch;
    int unsigned      pos;
    kept = '0;
    if (words_taken >= WORDS) return;
    for (int b = 0; b < 8; b++) begin
      pos = words_taken * 8 + b;
      ch  = chunk[8*b +: 8];
      if (key_ended) continue;
      if (ch == 8'h00) begin
        key_ended = 1'b1;
        continue;
      end
      if (pos >= ID_BYTES - 1) begin
        key_overlong = 1'b1;
        key_ended    = 1'b1;
        continue;
      end
      kept[8*b +: 8] = ch;
    end
    partial_key[words_taken] = kept;
    words_taken++;
  endfunction

  function automatic out_item_t lookup_or_claim();
    out_item_t ans;
    ans.slot_number = '0;
    ans.status      = ST_FULL;
    if (partial_key[0][7:0] == 8'h00) begin
      ans.status = ST_EMPTY_KEY;
    end else begin
      if (!key_overlong) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (ans.status == ST_FULL && slot_taken[i] && stored_keys[i] == partial_key) begin
            ans.status      = ST_FOUND;
            ans.slot_number = base_reg + 16'(i);
          end
        end
      end
      if (ans.status == ST_FULL) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (ans.status == ST_FULL && !slot_taken[i]) begin
            stored_keys[i]  = partial_key;
            slot_taken[i]   = 1'b1;
            ans.status      = ST_ALLOCATED;
            ans.slot_number = base_reg + 16'(i);
          end
        end
      end
    end
    drop_partial_key();
    return ans;
  endfunction

  function automatic void flag(string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      wipe_slots();
      base_reg = '0;
      answers_q.delete();
    end else begin
      // Compare the result first: a new beat may be taken on the same edge.
      if (out_valid) begin
        if (answers_q.size() == 0) begin
          flag($sformatf("unexpected result: slot %0d status %0d",
                         out_item.slot_number, out_item.status));
        end else begin
          want = answers_q.pop_front();
          if (want.slot_number !== out_item.slot_number || want.status !== out_item.status)
            flag($sformatf("mismatch: expected slot %0d status %0d, got slot %0d status %0d",
                           want.slot_number, want.status,
                           out_item.slot_number, out_item.status));
        end
      end
      if (start && !busy) begin
        if (in_item.opcode == OP_CLEAR) begin
          wipe_slots();
          want.slot_number = '0;
          want.status      = ST_CLEARED;
          answers_q.push_back(want);
        end else begin
          absorb_chunk(in_item.key_chunk);
          if (in_item.chunk_last) answers_q.push_back(lookup_or_claim());
        end
      end
      if (cfg_valid && cfg_ready) base_reg = cfg_data;
    end
    fail_count <= errors;
    pending    <= answers_q.size();
  end

endmodule

### tb/keyed_slot_dedup_allocator_tb.sv
// Testbench top for the keyed slot allocator: key stimulus, base writes, watchdog and verdict.
`timescale 1ns / 1ps
module keyed_slot_dedup_allocator_tb;
  import ksda_pkg::*;

  localparam int POOL_SIZE   = 24;
  localparam int PHASE_BEATS = 120;
  localparam int SETTLE      = 16;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_KEY     = 72;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  int         beats_sent = 0;
  int         idle_cycles = 0;
  bit         burst = 1'b0;
  logic [7:0] key_buf [128];
  int         key_len;
  logic [7:0] pool_chars [POOL_SIZE][MAX_KEY];
  int         pool_len [POOL_SIZE];

  keyed_slot_dedup_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  keyed_slot_dedup_allocator_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n && !((start && !busy) || out_valid || (cfg_valid && cfg_ready)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL keyed_slot_dedup_allocator");
      $finish;
    end
  end

  task automatic drive_beat(input logic op, input logic [KEY_W-1:0] chunk, input logic last);
    int       gap;
    in_item_t beat;
    gap             = burst ? 0 : $urandom_range(0, 12);
    beat.opcode     = op;
    beat.key_chunk  = chunk;
    beat.chunk_last = last;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  // Send key_buf[0:key_len-1] as chunks; noise fills bytes after the terminator.
  task automatic send_key(input int extra, input bit noise, input bit open_end);
    int               n;
    int               p;
    logic [KEY_W-1:0] chunk;
    n = key_len / 8 + 1;
    if (open_end && key_len > 0 && key_len % 8 == 0) n = key_len / 8;
    n += extra;
    for (int c = 0; c < n; c++) begin
      chunk = '0;
      for (int b = 0; b < 8; b++) begin
        p = c * 8 + b;
        if (p < key_len) chunk[8*b +: 8] = key_buf[p];
        else if (noise && p > key_len) chunk[8*b +: 8] = 8'($urandom);
      end
      drive_beat(OP_CHUNK, chunk, c == n - 1);
    end
  endtask

  task automatic send_clear();
    drive_beat(OP_CLEAR, {$urandom, $urandom}, 1'($urandom));
  endtask

  task automatic random_chars(input int len);
    key_len = len;
    for (int i = 0; i < len; i++) key_buf[i] = 8'($urandom_range(1, 255));
  endtask

  task automatic refill_pool(input int idx);
    pool_len[idx] = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 66)
                                                : $urandom_range(1, 20);
    for (int i = 0; i < pool_len[idx]; i++) pool_chars[idx][i] = 8'($urandom_range(1, 255));
  endtask

  task automatic load_pool(input int idx);
    key_len = pool_len[idx];
    for (int i = 0; i < key_len; i++) key_buf[i] = pool_chars[idx][i];
  endtask

  task automatic random_key();
    int r;
    int idx;
    int p;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, POOL_SIZE - 1);
    if ($urandom_range(0, 24) == 0) burst = !burst;
    if (r < 58) begin
      load_pool(idx);
      send_key(($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
               1'($urandom), $urandom_range(0, 3) == 0);
    end else if (r < 70) begin
      // near miss: one character off, or one shorter
      load_pool(idx);
      if (key_len > 1 && $urandom_range(0, 1) == 1) begin
        key_len--;
      end else begin
        p          = $urandom_range(0, key_len - 1);
        key_buf[p] = key_buf[p] % 8'd255 + 8'd1;
      end
      send_key(0, 1'($urandom), 1'b0);
    end else if (r < 80) begin
      random_chars($urandom_range(1, MAX_KEY));
      send_key($urandom_range(0, 2), 1'($urandom), 1'($urandom));
    end else if (r < 84) begin
      key_len = 0;
      send_key($urandom_range(0, 1), 1'b1, 1'b0);
    end else if (r < 87) begin
      send_clear();
    end else if (r < 93) begin
      // dangling chunks: either cleared away or merged into the next key
      repeat ($urandom_range(1, 2)) drive_beat(OP_CHUNK, {$urandom, $urandom}, 1'b0);
      if ($urandom_range(0, 1) == 1) send_clear();
    end else begin
      refill_pool(idx);
      load_pool(idx);
      send_key(0, 1'($urandom), 1'b0);
    end
  endtask

  task automatic finish_phase();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_base(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : main
    int          target;
    logic [15:0] base_val;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) refill_pool(i);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_base(16'h0000);
    key_len = 0;
    send_key(0, 1'b0, 1'b0);
    random_chars(8);
    for (int i = 0; i < 8; i++) key_buf[i] = 8'hFF;
    send_key(0, 1'b0, 1'b1);
    send_key(0, 1'b0, 1'b1);
    key_len    = 1;
    key_buf[0] = 8'h41;
    send_key(0, 1'b1, 1'b0);
    send_key(0, 1'b1, 1'b0);
    // overlong key stored truncated; the 63-character form then hits it
    key_len = 64;
    for (int i = 0; i < 64; i++) key_buf[i] = 8'hFF;
    send_key(0, 1'b0, 1'b1);
    key_len = 63;
    send_key(0, 1'b0, 1'b0);
    drive_beat(OP_CHUNK, 64'h0102_0304_0506_0708, 1'b0);
    send_clear();
    finish_phase();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1:       base_val = 16'hFFFF;
        3:       base_val = 16'hFFF8;
        4:       base_val = 16'h8000;
        default: base_val = 16'($urandom);
      endcase
      write_base(base_val);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) random_key();
      finish_phase();
    end

    if (fail_count == 0 && pending == 0)
      $display("PASS keyed_slot_dedup_allocator");
    else
      $display("FAIL keyed_slot_dedup_allocator");
    $finish;
  end

endmodule
